### src/nsd_pkg.sv
// Package for the NMEA sentence deframer: sizes, event codes, character
// constants, the hex digit decoder and the structs passed between modules.
// Depends on nothing.
`timescale 1ns / 1ps

package nsd_pkg;

  // Largest body that one sentence may carry.
  localparam int MAX_BODY = 128;
  // Index into one bank, and a length that can also hold MAX_BODY itself.
  localparam int IDX_W = $clog2(MAX_BODY);
  localparam int LEN_W = $clog2(MAX_BODY + 1);
  // The RAM holds two banks; the top address bit selects the bank.
  localparam int RAM_AW = IDX_W + 1;
  localparam int RAM_DEPTH = 2 * MAX_BODY;

  // Widths of the interface fields.
  localparam int READ_IDX_W = 7;
  localparam int READY_LEN_W = 8;
  localparam int COUNT_W = 32;

  // Commands.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result events.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;
  localparam logic [1:0] EV_OVERFLOW = 2'd3;

  // Framing characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Returns {digit_ok, nibble} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      res = {1'b1, 4'(ch - 8'h57)};
    end
    return res;
  endfunction

  // Access to the sentence RAM for one accepted request.
  typedef struct packed {
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
  } mem_req_t;

  // Result fields known when the request is accepted; read data follows.
  typedef struct packed {
    logic [1:0]             ev;
    logic [READY_LEN_W-1:0] ready_len;
    logic [COUNT_W-1:0]     acc;
    logic [COUNT_W-1:0]     err;
    logic [COUNT_W-1:0]     ovf;
    logic                   rd_hit;
  } result_t;

endpackage

### src/nsd_if.sv
// Channel interfaces of the NMEA sentence deframer: request and result.
// Depends on nsd_pkg for the field widths.
`timescale 1ns / 1ps

interface nsd_req_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [7:0]                     rx_byte;
  logic [nsd_pkg::READ_IDX_W-1:0] read_index;

  modport source (output valid, output command, output rx_byte, output read_index,
                  input ready);
  modport sink (input valid, input command, input rx_byte, input read_index,
                output ready);
endinterface

interface nsd_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      event_res;
  logic [nsd_pkg::READY_LEN_W-1:0] ready_length;
  logic [7:0]                      read_data;
  logic [nsd_pkg::COUNT_W-1:0]     accepted_count;
  logic [nsd_pkg::COUNT_W-1:0]     checksum_error_count;
  logic [nsd_pkg::COUNT_W-1:0]     overflow_count;

  modport source (output valid, output event_res, output ready_length,
                  output read_data, output accepted_count,
                  output checksum_error_count, output overflow_count,
                  input ready);
  modport sink (input valid, input event_res, input ready_length,
                input read_data, input accepted_count,
                input checksum_error_count, input overflow_count,
                output ready);
endinterface

### src/nmea_sentence_deframer.sv
// A result passes from the first stage register into the output register; it
// waits in the first stage while the output is occupied and not being taken.
// Throughput: one request per cycle while the output is free or being taken;
// the output register and the RAM read stage together hold two results, so one
// more request is taken while a finished result waits at the output.
// Reset (rst, synchronous, active high) returns the framer to idle, zeroes the
// lengths, checksum and counters, selects bank zero and empties both stages.
`timescale 1ns / 1ps

module nmea_sentence_deframer (
  input logic         clk,
  input logic         rst,
  nsd_req_if.sink     req,
  nsd_res_if.source   res
);

  // The framer holds all scalar state and decides each request in the cycle
  // in which it is accepted. The sentence bytes live in a two-bank RAM whose
  // read data is registered, so the other result fields are carried alongside
  // in a first stage register and the two are joined into the output register.

  nsd_pkg::mem_req_t mem_req;
  nsd_pkg::result_t  step;
  nsd_pkg::result_t  s1;
  logic              s1_valid;
  logic              s1_adv;
  logic              accept;
  logic [7:0]        rd_data;

  // The first stage empties whenever the output register is free or is
  // being taken. A request is accepted whenever the first stage is empty
  // or empties in this cycle; the RAM read register then only loads on an
  // accepted request, so it holds while the first stage is stalled.
  assign s1_adv = s1_valid && (!res.valid || res.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign accept = req.valid && req.ready;

  nsd_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (req.command),
    .rx_byte    (req.rx_byte),
    .read_index (req.read_index),
    .mem_req    (mem_req),
    .result     (step)
  );

  nsd_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_adv) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // A read outside the ready sentence, and every push, returns zero data.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res.event_res <= s1.ev;
      res.ready_length <= s1.ready_len;
      res.read_data <= s1.rd_hit ? rd_data : 8'd0;
      res.accepted_count <= s1.acc;
      res.checksum_error_count <= s1.err;
      res.overflow_count <= s1.ovf;
    end
  end

  // Every accepted request occupies the first stage in the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request lost before the first stage");

  // A result held in the first stage is neither dropped nor overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1)))
    else $error("stalled first stage changed");

  // A stalled first stage keeps the RAM read data it was issued with.
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> $stable(rd_data))
    else $error("RAM read data changed under a stalled result");

endmodule

### src/nsd_ram.sv
// Two-bank sentence RAM: one write and one registered read per cycle.
// Depends on nsd_pkg for the depth and the request struct.
`timescale 1ns / 1ps

module nsd_ram (
  input  logic              clk,
  input  nsd_pkg::mem_req_t mem_req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [0:nsd_pkg::RAM_DEPTH-1];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule

### src/nsd_framer.sv
// Sentence framing state machine, checksum, bank selection and counters.
// Depends on nsd_pkg; drives the RAM request and the result fields.
`timescale 1ns / 1ps

module nsd_framer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           command,
  input  logic [7:0]                     rx_byte,
  input  logic [nsd_pkg::READ_IDX_W-1:0] read_index,
  output nsd_pkg::mem_req_t              mem_req,
  output nsd_pkg::result_t               result
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW = 2'd3;

  logic [1:0]                  phase, phase_next;
  logic [nsd_pkg::LEN_W-1:0]   body_length, body_length_next;
  logic [7:0]                  running_xor, running_xor_next;
  logic [3:0]                  expected_high, expected_high_next;
  logic                        ready_bank, ready_bank_next;
  logic [nsd_pkg::LEN_W-1:0]   ready_count, ready_count_next;
  logic [nsd_pkg::COUNT_W-1:0] accepted_total, accepted_total_next;
  logic [nsd_pkg::COUNT_W-1:0] error_total, error_total_next;
  logic [nsd_pkg::COUNT_W-1:0] overflow_total, overflow_total_next;
  logic [1:0]                  ev;
  logic [4:0]                  nib;
  logic                        push;

  assign push = accept && (command == nsd_pkg::CMD_PUSH);
  assign nib = nsd_pkg::hex_nibble(rx_byte);

  always_comb begin
    phase_next = phase;
    body_length_next = body_length;
    running_xor_next = running_xor;
    expected_high_next = expected_high;
    ready_bank_next = ready_bank;
    ready_count_next = ready_count;
    accepted_total_next = accepted_total;
    error_total_next = error_total;
    overflow_total_next = overflow_total;
    ev = nsd_pkg::EV_NONE;
    mem_req.wr_en = 1'b0;
    mem_req.wr_addr = {~ready_bank, body_length[nsd_pkg::IDX_W-1:0]};
    mem_req.wr_data = rx_byte;

    if (push) begin
      if (rx_byte == nsd_pkg::CH_DOLLAR) begin
        phase_next = PH_BODY;
        body_length_next = '0;
        running_xor_next = 8'd0;
      end else begin
        unique case (phase)
          PH_BODY: begin
            if (rx_byte == nsd_pkg::CH_STAR) begin
              phase_next = PH_HIGH;
            end else if (rx_byte == nsd_pkg::CH_CR || rx_byte == nsd_pkg::CH_LF) begin
              ev = nsd_pkg::EV_ERROR;
            end else if (32'(body_length) >= nsd_pkg::MAX_BODY) begin
              ev = nsd_pkg::EV_OVERFLOW;
            end else begin
              mem_req.wr_en = 1'b1;
              body_length_next = body_length + 1'b1;
              running_xor_next = running_xor ^ rx_byte;
            end
          end
          PH_HIGH: begin
            if (!nib[4]) begin
              ev = nsd_pkg::EV_ERROR;
            end else begin
              expected_high_next = nib[3:0];
              phase_next = PH_LOW;
            end
          end
          PH_LOW: begin
            if (!nib[4] || {expected_high, nib[3:0]} != running_xor) begin
              ev = nsd_pkg::EV_ERROR;
            end else begin
              ev = nsd_pkg::EV_ACCEPT;
              ready_bank_next = ~ready_bank;
              ready_count_next = body_length;
            end
          end
          default: begin
          end
        endcase
        // Every event other than none ends the capture.
        if (ev != nsd_pkg::EV_NONE) begin
          phase_next = PH_IDLE;
          body_length_next = '0;
          running_xor_next = 8'd0;
        end
        if (ev == nsd_pkg::EV_ACCEPT) begin
          accepted_total_next = accepted_total + 1'b1;
        end
        if (ev == nsd_pkg::EV_ERROR) begin
          error_total_next = error_total + 1'b1;
        end
        if (ev == nsd_pkg::EV_OVERFLOW) begin
          overflow_total_next = overflow_total + 1'b1;
        end
      end
    end

    // Reads are served from the ready bank and only below its length.
    mem_req.rd_addr = {ready_bank, nsd_pkg::IDX_W'(read_index)};
    result.rd_hit = accept && (command == nsd_pkg::CMD_READ)
                    && (32'(read_index) < 32'(ready_count))
                    && (32'(read_index) < nsd_pkg::MAX_BODY);
    mem_req.rd_en = result.rd_hit;
    result.ev = ev;
    result.ready_len = nsd_pkg::READY_LEN_W'(ready_count_next);
    result.acc = accepted_total_next;
    result.err = error_total_next;
    result.ovf = overflow_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      body_length <= '0;
      running_xor <= 8'd0;
      expected_high <= 4'd0;
      ready_bank <= 1'b0;
      ready_count <= '0;
      accepted_total <= '0;
      error_total <= '0;
      overflow_total <= '0;
    end else begin
      phase <= phase_next;
      body_length <= body_length_next;
      running_xor <= running_xor_next;
      expected_high <= expected_high_next;
      ready_bank <= ready_bank_next;
      ready_count <= ready_count_next;
      accepted_total <= accepted_total_next;
      error_total <= error_total_next;
      overflow_total <= overflow_total_next;
    end
  end

  // A capture never writes into the bank that reads are served from.
  a_wr_capture_bank: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> mem_req.wr_addr[nsd_pkg::RAM_AW-1] != ready_bank)
    else $error("capture write hit the ready bank");

  // The banks swap only on an accepted sentence.
  a_swap_on_accept: assert property (@(posedge clk) disable iff (rst)
    (ready_bank != ready_bank_next) |-> (push && phase == PH_LOW && ev == nsd_pkg::EV_ACCEPT))
    else $error("bank swap without an accepted sentence");

  // A stored body never grows beyond the buffer.
  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    32'(body_length) <= nsd_pkg::MAX_BODY)
    else $error("body length beyond buffer size");

endmodule

### sim/tb.sv
// Testbench for nmea_sentence_deframer: a directed table and then random NMEA
// sentences, checked against table values or a behavioural predictor of the deframer.
// Depends on nsd_pkg, the nsd_req_if / nsd_res_if interfaces and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_DIRECTED = 27;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {PH_IDLE, PH_BODY, PH_HIGH, PH_LOW} frame_phase_t;

  typedef struct packed {
    logic                           command;
    logic [7:0]                     rx_byte;
    logic [nsd_pkg::READ_IDX_W-1:0] read_index;
  } request_t;

  typedef struct packed {
    logic [1:0]                      ev;
    logic [nsd_pkg::READY_LEN_W-1:0] ready_length;
    logic [7:0]                      read_data;
    logic [nsd_pkg::COUNT_W-1:0]     accepted;
    logic [nsd_pkg::COUNT_W-1:0]     errors;
    logic [nsd_pkg::COUNT_W-1:0]     overflows;
  } sentence_result_t;

  typedef struct packed {
    request_t         req;
    logic             typed;
    sentence_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  nsd_req_if req_ch ();
  nsd_res_if res_ch ();

  nmea_sentence_deframer uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed part. Rows with typed set carry their expected result; the
  // others are checked against the predictor.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // Reads before any sentence has been accepted, and a byte while idle.
    '{'{nsd_pkg::CMD_READ, 8'hFF, 7'd0}, 1'b1,
      '{nsd_pkg::EV_NONE, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0}},
    '{'{nsd_pkg::CMD_READ, 8'h00, 7'd127}, 1'b1,
      '{nsd_pkg::EV_NONE, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0}},
    '{'{nsd_pkg::CMD_PUSH, 8'h41, 7'd127}, 1'b1,
      '{nsd_pkg::EV_NONE, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0}},
    // "$GP*17" is accepted, then read back and read beyond its end.
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_DOLLAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h47, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h50, 7'd127}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_STAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h31, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h37, 7'd0}, 1'b1,
      '{nsd_pkg::EV_ACCEPT, 8'd2, 8'd0, 32'd1, 32'd0, 32'd0}},
    '{'{nsd_pkg::CMD_READ, 8'h00, 7'd0}, 1'b1,
      '{nsd_pkg::EV_NONE, 8'd2, 8'h47, 32'd1, 32'd0, 32'd0}},
    '{'{nsd_pkg::CMD_READ, 8'hFF, 7'd1}, 1'b1,
      '{nsd_pkg::EV_NONE, 8'd2, 8'h50, 32'd1, 32'd0, 32'd0}},
    '{'{nsd_pkg::CMD_READ, 8'h00, 7'd2}, 1'b1,
      '{nsd_pkg::EV_NONE, 8'd2, 8'd0, 32'd1, 32'd0, 32'd0}},
    // Extreme body bytes with a lower case checksum.
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_DOLLAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'hFF, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h00, 7'd127}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_STAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h66, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h66, 7'd0}, 1'b1,
      '{nsd_pkg::EV_ACCEPT, 8'd2, 8'd0, 32'd2, 32'd0, 32'd0}},
    // Carriage return inside the body.
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_DOLLAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_CR, 7'd0}, 1'b1,
      '{nsd_pkg::EV_ERROR, 8'd2, 8'd0, 32'd2, 32'd1, 32'd0}},
    // A character that is not a hex digit after the star.
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_DOLLAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_STAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h47, 7'd0}, 1'b1,
      '{nsd_pkg::EV_ERROR, 8'd2, 8'd0, 32'd2, 32'd2, 32'd0}},
    // Empty body with a checksum that does not match.
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_DOLLAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, nsd_pkg::CH_STAR, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h30, 7'd0}, 1'b0, '0},
    '{'{nsd_pkg::CMD_PUSH, 8'h31, 7'd0}, 1'b1,
      '{nsd_pkg::EV_ERROR, 8'd2, 8'd0, 32'd2, 32'd3, 32'd0}}
  };

  // Predictor state.
  frame_phase_t                phase_q = PH_IDLE;
  int                          body_len = 0;
  logic [7:0]                  body_xor = 8'd0;
  logic [3:0]                  sum_high = 4'd0;
  logic [7:0]                  sentence_bank [2][nsd_pkg::MAX_BODY];
  logic                        ready_sel = 1'b0;
  logic [7:0]                  ready_len = 8'd0;
  logic [nsd_pkg::COUNT_W-1:0] accepted_total = '0;
  logic [nsd_pkg::COUNT_W-1:0] error_total = '0;
  logic [nsd_pkg::COUNT_W-1:0] overflow_total = '0;

  sentence_result_t awaited_results [$];
  sentence_result_t got;
  sentence_result_t want;
  int mismatch_count = 0;
  int sent_count = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit ready_phase = 1'b0;
  int ready_run = 0;

  // Returns {is_hex, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_digit_value(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") begin
      return {1'b1, ch[3:0]};
    end
    if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
      return {1'b1, ch[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // Any byte that carries no framing meaning inside a body.
  function automatic logic [7:0] body_char();
    logic [7:0] ch;
    ch = 8'($urandom);
    while (ch == nsd_pkg::CH_DOLLAR || ch == nsd_pkg::CH_STAR ||
           ch == nsd_pkg::CH_CR || ch == nsd_pkg::CH_LF) begin
      ch = 8'($urandom);
    end
    return ch;
  endfunction

  // Advances the deframer state by one request and returns its result.
  function automatic sentence_result_t deframe_request(input request_t rq);
    sentence_result_t r;
    logic [4:0]       dig;
    r = '0;
    if (rq.command == nsd_pkg::CMD_READ) begin
      if (8'(rq.read_index) < ready_len) begin
        r.read_data = sentence_bank[ready_sel][rq.read_index];
      end
    end else if (rq.rx_byte == nsd_pkg::CH_DOLLAR) begin
      phase_q = PH_BODY;
      body_len = 0;
      body_xor = 8'd0;
    end else begin
      dig = hex_digit_value(rq.rx_byte);
      case (phase_q)
        PH_BODY: begin
          if (rq.rx_byte == nsd_pkg::CH_STAR) begin
            phase_q = PH_HIGH;
          end else if (rq.rx_byte == nsd_pkg::CH_CR || rq.rx_byte == nsd_pkg::CH_LF) begin
            r.ev = nsd_pkg::EV_ERROR;
          end else if (body_len >= nsd_pkg::MAX_BODY) begin
            r.ev = nsd_pkg::EV_OVERFLOW;
          end else begin
            sentence_bank[!ready_sel][body_len] = rq.rx_byte;
            body_len++;
            body_xor ^= rq.rx_byte;
          end
        end
        PH_HIGH: begin
          if (!dig[4]) begin
            r.ev = nsd_pkg::EV_ERROR;
          end else begin
            sum_high = dig[3:0];
            phase_q = PH_LOW;
          end
        end
        PH_LOW: begin
          if (!dig[4] || {sum_high, dig[3:0]} != body_xor) begin
            r.ev = nsd_pkg::EV_ERROR;
          end else begin
            // The capture bank becomes the ready bank.
            ready_sel = !ready_sel;
            ready_len = 8'(body_len);
            r.ev = nsd_pkg::EV_ACCEPT;
          end
        end
        default: ;
      endcase
      if (r.ev == nsd_pkg::EV_ACCEPT) accepted_total++;
      if (r.ev == nsd_pkg::EV_ERROR) error_total++;
      if (r.ev == nsd_pkg::EV_OVERFLOW) overflow_total++;
      if (r.ev != nsd_pkg::EV_NONE) begin
        phase_q = PH_IDLE;
        body_len = 0;
        body_xor = 8'd0;
      end
    end
    r.ready_length = ready_len;
    r.accepted = accepted_total;
    r.errors = error_total;
    r.overflows = overflow_total;
    return r;
  endfunction

  // Drives one request in bursts with random gaps and records its result.
  task automatic send_request(input request_t rq, input logic typed,
                              input sentence_result_t typed_result);
    int               gap;
    sentence_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 24);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= rq.command;
    req_ch.rx_byte <= rq.rx_byte;
    req_ch.read_index <= rq.read_index;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // The predictor follows every request, typed rows included.
    predicted = deframe_request(rq);
    awaited_results.push_back(typed ? typed_result : predicted);
    burst_left--;
    sent_count++;
  endtask

  // Pushes one character, now and then followed by a read of the ready sentence.
  task automatic push_char(input logic [7:0] ch);
    request_t rq;
    rq.command = nsd_pkg::CMD_PUSH;
    rq.rx_byte = ch;
    rq.read_index = nsd_pkg::READ_IDX_W'($urandom);
    send_request(rq, 1'b0, '0);
    if ($urandom_range(0, 7) == 0) begin
      rq.command = nsd_pkg::CMD_READ;
      rq.rx_byte = 8'($urandom);
      if (ready_len != 8'd0 && $urandom_range(0, 1) == 1) begin
        rq.read_index = nsd_pkg::READ_IDX_W'($urandom_range(0, int'(ready_len) - 1));
      end else begin
        rq.read_index = nsd_pkg::READ_IDX_W'($urandom);
      end
      send_request(rq, 1'b0, '0);
    end
  endtask

  // One sentence: mostly well formed, otherwise broken in one of several ways,
  // or plain line noise between sentences.
  task automatic random_sentence();
    int         kind;
    int         len;
    int         spot;
    int         pick;
    logic [7:0] sum;
    logic [7:0] bad;
    logic [7:0] ch;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6)) begin
        bad = 8'($urandom);
        push_char(bad == nsd_pkg::CH_DOLLAR ? nsd_pkg::CH_STAR : bad);
      end
      return;
    end
    pick = $urandom_range(0, 59);
    if (kind >= 88) begin
      len = nsd_pkg::MAX_BODY + $urandom_range(1, 2);
    end else if (pick == 0) begin
      len = nsd_pkg::MAX_BODY;
    end else if (pick == 1) begin
      len = $urandom_range(100, nsd_pkg::MAX_BODY);
    end else begin
      len = $urandom_range(0, 16);
    end
    // Position of the fault; for a restart, len + 1 and len + 2 fall in the checksum.
    spot = (kind >= 80 && kind < 85) ? $urandom_range(0, len + 2) : $urandom_range(0, len);
    bad = 8'($urandom);
    while (hex_digit_value(bad) != 5'd0 || bad == nsd_pkg::CH_DOLLAR) bad = 8'($urandom);
    sum = 8'd0;
    push_char(nsd_pkg::CH_DOLLAR);
    for (int i = 0; i < len; i++) begin
      if (kind >= 74 && kind < 80 && i == spot) begin
        push_char($urandom_range(0, 1) ? nsd_pkg::CH_CR : nsd_pkg::CH_LF);
        return;
      end
      if (kind >= 80 && kind < 85 && i == spot) begin
        push_char(nsd_pkg::CH_DOLLAR);
        sum = 8'd0;
      end
      ch = body_char();
      push_char(ch);
      sum ^= ch;
    end
    if (kind >= 74 && kind < 80) begin
      push_char($urandom_range(0, 1) ? nsd_pkg::CH_CR : nsd_pkg::CH_LF);
      return;
    end
    push_char(nsd_pkg::CH_STAR);
    if (kind >= 80 && kind < 85 && spot == len + 1) begin
      push_char(nsd_pkg::CH_DOLLAR);
      return;
    end
    if (kind >= 60 && kind < 68) sum ^= 8'($urandom_range(1, 255));
    if (kind >= 68 && kind < 74 && $urandom_range(0, 1) == 1) begin
      push_char(bad);
      return;
    end
    push_char(hex_char(sum[7:4]));
    if (kind >= 80 && kind < 85 && spot == len + 2) begin
      push_char(nsd_pkg::CH_DOLLAR);
      return;
    end
    push_char((kind >= 68 && kind < 74) ? bad : hex_char(sum[3:0]));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Result side: checks every accepted result and stalls on runs of its own.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.event_res, res_ch.ready_length, res_ch.read_data,
              res_ch.accepted_count, res_ch.checksum_error_count, res_ch.overflow_count};
      if (awaited_results.size() == 0) begin
        $display("%0t: expected no result, got event %0d", $time, got.ev);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("event_res", 32'(want.ev), 32'(got.ev));
        check_field("ready_length", 32'(want.ready_length), 32'(got.ready_length));
        check_field("read_data", 32'(want.read_data), 32'(got.read_data));
        check_field("accepted_count", want.accepted, got.accepted);
        check_field("checksum_error_count", want.errors, got.errors);
        check_field("overflow_count", want.overflows, got.overflows);
      end
    end
    if (ready_run == 0) begin
      ready_phase = !ready_phase;
      if (ready_phase) begin
        ready_run = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      end else begin
        ready_run = $urandom_range(1, 5);
      end
    end
    ready_run--;
    res_ch.ready <= ready_phase;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out with %0d results outstanding", $time, awaited_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = nsd_pkg::CMD_PUSH;
    req_ch.rx_byte = 8'd0;
    req_ch.read_index = '0;
    res_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    while (sent_count < NUM_DIRECTED + RANDOM_ITEMS) random_sentence();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/nsd_pkg.sv
src/nsd_if.sv
src/nsd_ram.sv
src/nsd_framer.sv
src/nmea_sentence_deframer.sv
sim/tb.sv
